@@ hw/rtl/ffci_pkg.sv @@
package ffci_pkg;

  localparam int BufferBytes = 10;
  localparam int FrameLen    = 9;
  localparam int CountW      = $clog2(BufferBytes + 1);

  localparam logic [7:0] HeadMark      = 8'hFE;
  localparam logic [7:0] TailMark      = 8'hAA;
  localparam logic [7:0] QualityReset  = 8'd30;

  localparam int VelXW     = 17;
  localparam int VelYW     = 16;
  localparam int PosW      = 32;
  localparam int OutBits   = VelXW + VelYW + 2 * PosW;
  localparam int OutTdataW = ((OutBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CmdData  = 2'd0,
    CmdEnd   = 2'd1,
    CmdClear = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StTaken   = 3'd0,
    StOk      = 3'd1,
    StFraming = 3'd2,
    StSum     = 3'd3,
    StQuality = 3'd4,
    StCleared = 3'd5
  } status_e;

  typedef logic [7:0] octet_t;
  typedef octet_t [BufferBytes-1:0] store_t;

  typedef struct packed {
    logic valid;
    cmd_e cmd;
    logic len_ok;
  } step_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VelXW-1:0]   vel_x;
    logic signed [VelYW-1:0]   vel_y;
    logic signed [PosW-1:0]    pos_x;
    logic signed [PosW-1:0]    pos_y;
  } result_t;

endpackage

@@ hw/rtl/ffci_cell.sv @@
module ffci_cell (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  ffci_pkg::octet_t     byte_i,
  output ffci_pkg::octet_t     byte_o
);

  ffci_pkg::octet_t byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

@@ hw/rtl/ffci_integ.sv @@
module ffci_integ (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffci_pkg::step_t      step_i,
  input  ffci_pkg::store_t     store_i,
  input  logic [7:0]           thresh_i,
  output ffci_pkg::result_t    res_o
);

  // oldest byte sits deepest in the chain: frame byte k is at cell FrameLen-1-k
  localparam int LastCell = ffci_pkg::FrameLen - 1;

  logic signed [ffci_pkg::VelXW-1:0] vel_x_q, vel_x_d, vel_x_new;
  logic signed [ffci_pkg::VelYW-1:0] vel_y_q, vel_y_d, vel_y_new;
  logic signed [ffci_pkg::PosW-1:0]  pos_x_q, pos_x_d;
  logic signed [ffci_pkg::PosW-1:0]  pos_y_q, pos_y_d;
  ffci_pkg::octet_t b_head, b_xl, b_xh, b_yl, b_yh, b_chk, b_qual, b_tail;
  logic [7:0]  chk;
  logic [15:0] raw_x;
  logic        framing_ok;
  ffci_pkg::status_e status;

  always_comb begin
    b_head = store_i[LastCell];
    b_xl   = store_i[LastCell - 2];
    b_xh   = store_i[LastCell - 3];
    b_yl   = store_i[LastCell - 4];
    b_yh   = store_i[LastCell - 5];
    b_chk  = store_i[LastCell - 6];
    b_qual = store_i[LastCell - 7];
    b_tail = store_i[LastCell - 8];

    framing_ok = step_i.len_ok && (b_head == ffci_pkg::HeadMark) &&
                 (b_tail == ffci_pkg::TailMark);
    chk        = b_xl + b_xh + b_yl + b_yh;
    raw_x      = {b_xh, b_xl};
    vel_x_new  = -{raw_x[15], raw_x};
    vel_y_new  = {b_yh, b_yl};

    status  = ffci_pkg::StTaken;
    vel_x_d = vel_x_q;
    vel_y_d = vel_y_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;

    unique case (step_i.cmd)
      ffci_pkg::CmdEnd: begin
        if (!framing_ok) begin
          status = ffci_pkg::StFraming;
        end else if (chk != b_chk) begin
          status = ffci_pkg::StSum;
        end else if (b_qual <= thresh_i) begin
          status = ffci_pkg::StQuality;
        end else begin
          status  = ffci_pkg::StOk;
          vel_x_d = vel_x_new;
          vel_y_d = vel_y_new;
          pos_x_d = pos_x_q + {{(ffci_pkg::PosW - ffci_pkg::VelXW){vel_x_new[16]}}, vel_x_new};
          pos_y_d = pos_y_q + {{(ffci_pkg::PosW - ffci_pkg::VelYW){vel_y_new[15]}}, vel_y_new};
        end
      end
      ffci_pkg::CmdClear: begin
        status  = ffci_pkg::StCleared;
        pos_x_d = '0;
        pos_y_d = '0;
      end
      ffci_pkg::CmdData, ffci_pkg::CmdNone: begin
        status = ffci_pkg::StTaken;
      end
      default: begin
        status = ffci_pkg::StTaken;
      end
    endcase

    res_o.status = status;
    res_o.vel_x  = vel_x_d;
    res_o.vel_y  = vel_y_d;
    res_o.pos_x  = pos_x_d;
    res_o.pos_y  = pos_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_x_q <= '0;
      vel_y_q <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (step_i.valid) begin
      vel_x_q <= vel_x_d;
      vel_y_q <= vel_y_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

endmodule

@@ hw/rtl/ffci_skid.sv @@
module ffci_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ffci_pkg::result_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ffci_pkg::result_t    out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  ffci_pkg::result_t out_q, out_d;
  ffci_pkg::result_t skid_q, skid_d;
  logic              take_in;

  assign in_ready_o = !skid_valid_q;
  assign take_in    = in_valid_i && !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = in_data_i;
        out_valid_d = take_in;
      end
    end else if (take_in) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/flow_frame_check_and_integrate.sv @@
// Optical-flow frame checker and motion integrator. Each input beat is a data byte, a frame
// end, a position clear or no command (s_axis_tuser_i), and each produces exactly one output beat with
// a status and the velocity and position after that beat. Bytes shift into a row of byte
// cells (up to BufferBytes, extra bytes dropped); a frame end checks length, head/tail marks,
// checksum and quality against the threshold, and on success updates velocity and the
// wrapping 32-bit positions. One beat per clock is sustained while the output takes beats: the
// check and both position adds finish in the cycle a beat is taken, and a two-entry output
// buffer keeps the input open while one result waits. Each result is registered in that buffer.
module flow_frame_check_and_integrate (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]   s_axis_tuser_i,   // [1:0] cmd
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [ffci_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // [16:0] velocity_x, [32:17] velocity_y, [64:33] position_x, [96:65] position_y, zeros above
  output logic [2:0]   m_axis_tuser_o    // [2:0] status
);

  logic [7:0]                     thresh_q;
  logic [ffci_pkg::CountW-1:0]    count_q, count_d;
  logic                           accept;
  logic                           shift;
  ffci_pkg::cmd_e                 cmd;
  ffci_pkg::store_t               store;
  ffci_pkg::step_t                step;
  ffci_pkg::result_t              res, out_res;

  assign cmd    = ffci_pkg::cmd_e'(s_axis_tuser_i);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign shift  = accept && (cmd == ffci_pkg::CmdData) &&
                  (count_q < ffci_pkg::CountW'(ffci_pkg::BufferBytes));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ffci_pkg::QualityReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (shift) begin
      count_d = count_q + 1'b1;
    end else if (accept && (cmd == ffci_pkg::CmdEnd)) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < ffci_pkg::BufferBytes; i++) begin : g_cell
    if (i == 0) begin : g_first
      ffci_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .byte_i  (s_axis_tdata_i),
        .byte_o  (store[i])
      );
    end else begin : g_next
      ffci_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .byte_i  (store[i-1]),
        .byte_o  (store[i])
      );
    end
  end

  always_comb begin
    step.valid  = accept;
    step.cmd    = cmd;
    step.len_ok = (count_q == ffci_pkg::CountW'(ffci_pkg::FrameLen));
  end

  ffci_integ u_integ (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .store_i  (store),
    .thresh_i (thresh_q),
    .res_o    (res)
  );

  ffci_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  assign m_axis_tuser_o = out_res.status;
  assign m_axis_tdata_o = {{(ffci_pkg::OutTdataW - ffci_pkg::OutBits){1'b0}},
                           out_res.pos_y, out_res.pos_x, out_res.vel_y, out_res.vel_x};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ffci_pkg::CountW'(ffci_pkg::BufferBytes))
    else $error("byte count above buffer size");

  a_end_resets_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == ffci_pkg::CmdEnd) |=> count_q == '0)
    else $error("frame end did not clear byte count");

  a_bad_len_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == ffci_pkg::CmdEnd) &&
    (count_q != ffci_pkg::CountW'(ffci_pkg::FrameLen)) |-> res.status != ffci_pkg::StOk)
    else $error("frame of wrong length accepted");

  a_out_drop_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid_o) |-> $past(m_axis_tready_i))
    else $error("output beat withdrawn before it was taken");
`endif

endmodule
